FILE: rtl/morq_pkg.sv
package morq_pkg;

    localparam int COORD_BITS = 32;
    localparam int CODE_W     = 64;
    localparam int LEVEL_W    = 5;
    localparam int NBR_NUM    = 9;

    // Wide enough to hold 2^level for the largest level and any coordinate
    localparam int SIDE_W = (2 ** LEVEL_W > COORD_BITS) ? 2 ** LEVEL_W : COORD_BITS;
    localparam int CMP_W  = SIDE_W + 1;

    // Bit positions in the candidate mask, in emit order
    localparam int NBR_CENTRE = 0;
    localparam int NBR_XM_Y   = 1;
    localparam int NBR_XM_YM  = 2;
    localparam int NBR_XM_YP  = 3;
    localparam int NBR_XP_Y   = 4;
    localparam int NBR_XP_YM  = 5;
    localparam int NBR_XP_YP  = 6;
    localparam int NBR_X_YM   = 7;
    localparam int NBR_X_YP   = 8;

    typedef logic [CODE_W-1:0]     code_t;
    typedef logic [LEVEL_W-1:0]    level_t;
    typedef logic [COORD_BITS-1:0] coord_t;
    typedef logic [NBR_NUM-1:0]    nbr_mask_t;

    typedef struct packed {
        code_t     code;
        level_t    level;
        nbr_mask_t done;
    } item_t;

    typedef struct packed {
        nbr_mask_t pick;
        code_t     code;
        logic      last;
    } nbr_pick_t;

    // Gather the even bits of a Morton code into one coordinate
    function automatic coord_t compact_even(input code_t v);
        coord_t c;
        c = '0;
        for (int i = 0; i < COORD_BITS; i++)
        begin
            c[i] = v[2 * i];
        end
        return c;
    endfunction

    // Place a coordinate on the even bits of a code
    function automatic code_t spread_even(input coord_t c);
        code_t v;
        v = '0;
        for (int i = 0; i < COORD_BITS; i++)
        begin
            v[2 * i] = c[i];
        end
        return v;
    endfunction

endpackage

FILE: rtl/morq_if.sv
interface morq_in_if
    import morq_pkg::*;
();
    logic   valid;
    logic   ready;
    code_t  box_code;
    level_t grid_level;

    modport source (output valid, output box_code, output grid_level, input ready);
    modport sink   (input valid, input box_code, input grid_level, output ready);
endinterface

interface morq_out_if
    import morq_pkg::*;
();
    logic  valid;
    logic  ready;
    code_t neighbour_code;
    logic  last_of_run;

    modport source (output valid, output neighbour_code, output last_of_run, input ready);
    modport sink   (input valid, input neighbour_code, input last_of_run, output ready);
endinterface

FILE: rtl/morton_quadtree_neighbours_top.sv
// Each result is offered from the output register, loaded from the held item.
// Throughput: one result per cycle while nbr_out.ready does not stall the
// output; an item giving 1 to 9 results holds the item register until its last
// result moves into the output register; the next item is taken in that cycle.
// Reset: rst_n asynchronous, active low; clears the item and output valid flags.
module morton_quadtree_neighbours_top
    import morq_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    morq_in_if.sink    box_in,
    morq_out_if.source nbr_out
);

    item_t     item;
    logic      item_valid;
    nbr_pick_t pick;
    logic      can_load;
    logic      issue;

    assign issue = item_valid && can_load;

    morq_slot u_slot (
        .clk        (clk),
        .rst_n      (rst_n),
        .box_in     (box_in),
        .issue      (issue),
        .issue_pick (pick),
        .item       (item),
        .item_valid (item_valid)
    );

    morq_nbr_calc u_calc (
        .item (item),
        .pick (pick)
    );

    morq_out_reg u_out (
        .clk      (clk),
        .rst_n    (rst_n),
        .load_req (item_valid),
        .pick     (pick),
        .can_load (can_load),
        .nbr_out  (nbr_out)
    );

endmodule

FILE: rtl/morq_nbr_calc.sv
module morq_nbr_calc
    import morq_pkg::*;
(
    input  item_t     item,
    output nbr_pick_t pick
);

    coord_t    x;
    coord_t    y;
    logic [CMP_W-1:0] top;
    logic      x_lo;
    logic      x_hi;
    logic      y_lo;
    logic      y_hi;
    nbr_mask_t avail;
    nbr_mask_t pending;
    nbr_mask_t oh;
    logic      minus_x;
    logic      plus_x;
    logic      minus_y;
    logic      plus_y;
    coord_t    xs;
    coord_t    ys;

    always_comb
    begin
        x    = compact_even(item.code);
        y    = compact_even(item.code >> 1);
        top  = (CMP_W'(1) << item.level) - CMP_W'(1);
        x_lo = (x != '0);
        y_lo = (y != '0);
        x_hi = (CMP_W'(x) < top);
        y_hi = (CMP_W'(y) < top);

        avail             = '0;
        avail[NBR_CENTRE] = 1'b1;
        avail[NBR_XM_Y]   = x_lo;
        avail[NBR_XM_YM]  = x_lo & y_lo;
        avail[NBR_XM_YP]  = x_lo & y_hi;
        avail[NBR_XP_Y]   = x_hi;
        avail[NBR_XP_YM]  = x_hi & y_lo;
        avail[NBR_XP_YP]  = x_hi & y_hi;
        avail[NBR_X_YM]   = y_lo;
        avail[NBR_X_YP]   = y_hi;

        // Take the lowest candidate not yet sent
        pending = avail & ~item.done;
        oh      = pending & (~pending + NBR_NUM'(1));

        minus_x = oh[NBR_XM_Y] | oh[NBR_XM_YM] | oh[NBR_XM_YP];
        plus_x  = oh[NBR_XP_Y] | oh[NBR_XP_YM] | oh[NBR_XP_YP];
        minus_y = oh[NBR_XM_YM] | oh[NBR_XP_YM] | oh[NBR_X_YM];
        plus_y  = oh[NBR_XM_YP] | oh[NBR_XP_YP] | oh[NBR_X_YP];

        xs = minus_x ? (x - COORD_BITS'(1)) : (plus_x ? (x + COORD_BITS'(1)) : x);
        ys = minus_y ? (y - COORD_BITS'(1)) : (plus_y ? (y + COORD_BITS'(1)) : y);

        pick.pick = oh;
        pick.code = oh[NBR_CENTRE] ? item.code : (spread_even(xs) | (spread_even(ys) << 1));
        pick.last = ((pending & ~oh) == '0);
    end

endmodule

FILE: rtl/morq_slot.sv
module morq_slot
    import morq_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    morq_in_if.sink   box_in,
    input  logic      issue,
    input  nbr_pick_t issue_pick,
    output item_t     item,
    output logic      item_valid
);

    logic      valid_reg;
    logic      valid_next;
    nbr_mask_t done_reg;
    nbr_mask_t done_next;
    code_t     code_reg;
    level_t    level_reg;
    logic      accept;
    logic      retire;

    assign retire       = issue && issue_pick.last;
    assign box_in.ready = !valid_reg || retire;
    assign accept       = box_in.valid && box_in.ready;

    always_comb
    begin
        valid_next = valid_reg;
        done_next  = done_reg;
        if (accept)
        begin
            valid_next = 1'b1;
            done_next  = '0;
        end
        else if (retire)
        begin
            valid_next = 1'b0;
        end
        else if (issue)
        begin
            done_next = done_reg | issue_pick.pick;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            done_reg  <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            done_reg  <= done_next;
        end
    end

    // Hold the item while its results go out
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            code_reg  <= box_in.box_code;
            level_reg <= box_in.grid_level;
        end
    end

    assign item.code  = code_reg;
    assign item.level = level_reg;
    assign item.done  = done_reg;
    assign item_valid = valid_reg;

    a_pick_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg |-> $onehot(issue_pick.pick))
        else $error("no single candidate picked for a held item");

    a_centre_first: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg && done_reg != '0) |-> done_reg[NBR_CENTRE])
        else $error("neighbour sent before the centre code");

    a_hold_until_last: assert property (@(posedge clk) disable iff (!rst_n)
        (issue && !issue_pick.last) |=> (valid_reg && done_reg != '0))
        else $error("item dropped before its last result");

endmodule

FILE: rtl/morq_out_reg.sv
module morq_out_reg
    import morq_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      load_req,
    input  nbr_pick_t pick,
    output logic      can_load,
    morq_out_if.source nbr_out
);

    logic  valid_reg;
    logic  valid_next;
    code_t code_reg;
    logic  last_reg;
    logic  load;

    assign can_load = !valid_reg || nbr_out.ready;
    assign load     = load_req && can_load;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (nbr_out.ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            code_reg <= pick.code;
            last_reg <= pick.last;
        end
    end

    assign nbr_out.valid          = valid_reg;
    assign nbr_out.neighbour_code = code_reg;
    assign nbr_out.last_of_run    = last_reg;

endmodule

FILE: tb/morton_quadtree_neighbours_top_tb.sv
module morton_quadtree_neighbours_top_tb;
    import morq_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 400_000;
    localparam int RANDOM_ITEMS = 210;
    localparam int SETTLE_CYCLES = 20;

    typedef struct {
        code_t  code;
        level_t level;
        bit     drain;
    } box_req_t;

    typedef struct {
        code_t code;
        logic  last;
    } nbr_expect_t;

    logic clk = 1'b0;
    logic rst_n;

    morq_in_if  box_in();
    morq_out_if nbr_out();

    morton_quadtree_neighbours_top dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .box_in  (box_in),
        .nbr_out (nbr_out)
    );

    box_req_t    box_queue[$];
    nbr_expect_t nbr_expect[$];
    box_req_t    next_box;
    nbr_expect_t got_exp;

    int  cycles;
    int  errors;
    int  send_gap;
    int  stall_left;
    int  boxes_taken;
    int  codes_checked;
    int  centre_only_runs;
    int  full_runs;
    bit  all_drained;
    bit  calm;

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Gather every second bit, starting at bit 0
    function automatic coord_t even_bits(input code_t v);
        coord_t c;
        for (int i = 0; i < COORD_BITS; i++)
        begin
            c[i] = v[2 * i];
        end
        return c;
    endfunction

    // x on even bits, y on odd bits
    function automatic code_t merge_xy(input coord_t x, input coord_t y);
        code_t v;
        v = '0;
        for (int i = 0; i < COORD_BITS; i++)
        begin
            v[2 * i]     = x[i];
            v[2 * i + 1] = y[i];
        end
        return v;
    endfunction

    function automatic void predict_neighbours(input code_t code, input level_t lvl);
        logic [63:0] top;
        coord_t      x;
        coord_t      y;
        logic        y_dn;
        logic        y_up;
        code_t       run[$];
        nbr_expect_t e;
        top  = (64'd1 << lvl) - 64'd1;
        x    = even_bits(code);
        y    = even_bits(code >> 1);
        y_dn = (y != '0);
        y_up = ({32'd0, y} < top);
        run.push_back(code);
        if (x != '0)
        begin
            run.push_back(merge_xy(x - 32'd1, y));
            if (y_dn)
                run.push_back(merge_xy(x - 32'd1, y - 32'd1));
            if (y_up)
                run.push_back(merge_xy(x - 32'd1, y + 32'd1));
        end
        if ({32'd0, x} < top)
        begin
            run.push_back(merge_xy(x + 32'd1, y));
            if (y_dn)
                run.push_back(merge_xy(x + 32'd1, y - 32'd1));
            if (y_up)
                run.push_back(merge_xy(x + 32'd1, y + 32'd1));
        end
        if (y_dn)
            run.push_back(merge_xy(x, y - 32'd1));
        if (y_up)
            run.push_back(merge_xy(x, y + 32'd1));
        foreach (run[i])
        begin
            e.code = run[i];
            e.last = (i == run.size() - 1);
            nbr_expect.push_back(e);
        end
        if (run.size() == 1)
            centre_only_runs++;
        if (run.size() == NBR_NUM)
            full_runs++;
    endfunction

    // Mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    // Edges, just outside the grid, or anywhere inside
    function automatic coord_t pick_coord(input level_t lvl);
        coord_t top;
        int     s;
        top = (32'd1 << lvl) - 32'd1;
        s = $urandom_range(0, 9);
        if (s == 0)
            return '0;
        if (s == 1)
            return top;
        if (s == 2)
            return top + 32'd1;
        return $urandom_range(0, top);
    endfunction

    function automatic void add_box(input code_t code, input level_t lvl, input bit drain);
        box_req_t b;
        b.code  = code;
        b.level = lvl;
        b.drain = drain;
        box_queue.push_back(b);
    endfunction

    always @(posedge clk)
    begin
        cycles++;
        calm = ((cycles / 400) % 5) == 2;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles, %0d codes still owed", cycles, nbr_expect.size());
            $display("*** FAILED ***");
            $finish;
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            box_in.valid      <= 1'b0;
            box_in.box_code   <= '0;
            box_in.grid_level <= '0;
            send_gap = 0;
        end
        else if (!box_in.valid || box_in.ready)
        begin
            // a drain item waits for an idle channel and no results owed
            if (send_gap > 0 || box_queue.size() == 0 ||
                (box_queue[0].drain && (box_in.valid || !all_drained)))
            begin
                box_in.valid <= 1'b0;
                if (send_gap > 0)
                    send_gap--;
            end
            else
            begin
                next_box = box_queue.pop_front();
                box_in.valid      <= 1'b1;
                box_in.box_code   <= next_box.code;
                box_in.grid_level <= next_box.level;
                send_gap = calm ? 0 : pick_gap();
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            nbr_out.ready <= 1'b0;
            all_drained   <= 1'b1;
            stall_left = 0;
        end
        else
        begin
            if (box_in.valid && box_in.ready)
            begin
                predict_neighbours(box_in.box_code, box_in.grid_level);
                boxes_taken++;
            end
            if (nbr_out.valid && nbr_out.ready)
            begin
                if (nbr_expect.size() == 0)
                begin
                    $error("neighbour_code: expected nothing, got %h", nbr_out.neighbour_code);
                    errors++;
                end
                else
                begin
                    got_exp = nbr_expect.pop_front();
                    if (nbr_out.neighbour_code !== got_exp.code)
                    begin
                        $error("neighbour_code: expected %h, got %h",
                               got_exp.code, nbr_out.neighbour_code);
                        errors++;
                    end
                    if (nbr_out.last_of_run !== got_exp.last)
                    begin
                        $error("last_of_run: expected %0b, got %0b",
                               got_exp.last, nbr_out.last_of_run);
                        errors++;
                    end
                    codes_checked++;
                end
            end
            all_drained <= (nbr_expect.size() == 0);
            if (stall_left > 0)
            begin
                nbr_out.ready <= 1'b0;
                stall_left--;
            end
            else
            begin
                nbr_out.ready <= 1'b1;
                stall_left = calm ? 0 : pick_gap();
            end
        end
    end

    initial
    begin
        coord_t   x;
        coord_t   y;
        level_t   lvl;
        coord_t   top31;
        int       r;

        rst_n = 1'b0;
        box_in.valid      = 1'b0;
        box_in.box_code   = '0;
        box_in.grid_level = '0;
        nbr_out.ready     = 1'b0;
        top31 = 32'h7FFF_FFFF;

        // level zero: centre alone, or lower neighbours for an outside centre
        add_box(64'd0, 5'd0, 1'b0);
        add_box({64{1'b1}}, 5'd0, 1'b0);
        // level one corners
        add_box(merge_xy(32'd0, 32'd0), 5'd1, 1'b0);
        add_box(merge_xy(32'd1, 32'd0), 5'd1, 1'b0);
        add_box(merge_xy(32'd0, 32'd1), 5'd1, 1'b0);
        add_box(merge_xy(32'd1, 32'd1), 5'd1, 1'b0);
        // interior, all nine
        add_box(merge_xy(32'd1, 32'd1), 5'd2, 1'b0);
        add_box(merge_xy(32'd1, 32'd2), 5'd2, 1'b0);
        // edges of a mid grid
        add_box(merge_xy(32'd0, 32'd17), 5'd5, 1'b0);
        add_box(merge_xy(32'd31, 32'd17), 5'd5, 1'b0);
        add_box(merge_xy(32'd17, 32'd0), 5'd5, 1'b0);
        add_box(merge_xy(32'd17, 32'd31), 5'd5, 1'b0);
        // largest level
        add_box(merge_xy(32'd0, 32'd0), 5'd31, 1'b0);
        add_box(merge_xy(top31, top31), 5'd31, 1'b0);
        add_box(merge_xy(top31 >> 1, top31 >> 1), 5'd31, 1'b0);
        add_box(merge_xy(top31 + 32'd1, 32'd5), 5'd31, 1'b0);
        add_box({64{1'b1}}, 5'd31, 1'b0);
        add_box(64'hAAAA_AAAA_AAAA_AAAA, 5'd31, 1'b0);
        add_box(64'h5555_5555_5555_5555, 5'd3, 1'b0);
        // centre outside in y only
        add_box(merge_xy(32'd3, 32'd70000), 5'd16, 1'b0);
        add_box(64'h8000_0000_0000_0001, 5'd10, 1'b1);

        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            r = $urandom_range(0, 99);
            if ($urandom_range(0, 9) < 4)
                lvl = level_t'($urandom_range(0, 4));
            else
                lvl = level_t'($urandom_range(0, 31));
            if (r < 15)
            begin
                add_box({$urandom, $urandom}, lvl, i == 100 || i == 200);
            end
            else
            begin
                x = pick_coord(lvl);
                y = pick_coord(lvl);
                add_box(merge_xy(x, y), lvl, i == 100 || i == 200);
            end
        end

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        do
            @(negedge clk);
        while (box_queue.size() != 0 || box_in.valid || nbr_expect.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge clk);

        $display("Covered %0d box codes over levels 0 to 31, %0d neighbour codes compared",
                 boxes_taken, codes_checked);
        $display("Runs with the centre alone: %0d, runs with all eight neighbours: %0d",
                 centre_only_runs, full_runs);
        if (errors == 0)
        begin
            $display("*** PASSED ***");
        end
        else
        begin
            $display("%0d mismatches", errors);
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
